[rtl/core/pssm_pkg.sv]
// Shared types, constants and elaboration-time table functions for the sine synth mixer.
package pssm_pkg;

    // Default sizes
    localparam int VOICES_DEF    = 13;
    localparam int SINE_BITS_DEF = 10;
    localparam int NUM_NOTES     = 13;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 16;
    localparam int AMP_W    = 15;
    localparam int PHASE_W  = 32;
    localparam int MAG_W    = 15;
    localparam int KEY_W    = 13;
    localparam int STICK_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Envelope full scale (1.0 in Q1.15)
    localparam logic [VOL_W-1:0] VOL_MAX = 16'h8000;

    // sine * volume * amplitude fits in this many signed bits
    localparam int PROD_W    = 46;
    localparam int P1_W      = 32;
    localparam int MIX_SHIFT = 30;

    // Item kinds
    localparam logic ACT_CTRL  = 1'b0;
    localparam logic ACT_AUDIO = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STK_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STK_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL    = 3'd5;

    // Octave shift, 3-bit two's complement
    localparam logic [2:0] OCT_MIN  = 3'b110;
    localparam logic [2:0] OCT_MAX  = 3'b011;
    localparam logic [2:0] OCT_BIAS = 3'd2;

    // Horner coefficients, Q30
    localparam logic [63:0] SIN_C1  = 64'd1686629713;
    localparam logic [63:0] SIN_C3  = 64'd693598668;
    localparam logic [63:0] SIN_C5  = 64'd85569306;
    localparam logic [63:0] SIN_C7  = 64'd5026995;
    localparam logic [63:0] SIN_C9  = 64'd172272;
    localparam logic [63:0] SIN_C11 = 64'd3864;

    typedef struct packed {
        logic [VOL_W-1:0]   vol;
        logic [PHASE_W-1:0] phase;
    } t_voice;

    typedef struct packed {
        logic             vld;
        logic             snd;
        logic [VOL_W-1:0] vol;
    } t_mac_ctl;

    // Quarter-wave magnitude, evaluated at elaboration only
    function automatic logic [MAG_W-1:0] sine_mag(input int unsigned k, input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        x  = 64'(k) << (30 - qbits);
        x2 = (x * x) >> 30;
        r  = SIN_C11;
        r  = SIN_C9 - ((r * x2) >> 30);
        r  = SIN_C7 - ((r * x2) >> 30);
        r  = SIN_C5 - ((r * x2) >> 30);
        r  = SIN_C3 - ((r * x2) >> 30);
        r  = SIN_C1 - ((r * x2) >> 30);
        r  = (r * x) >> 30;
        r  = (r * 64'd32767 + (64'd1 << 29)) >> 30;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[MAG_W-1:0];
    endfunction

    // Phase increment per sample at octave 0 scaled by 2^2, C4 upward
    function automatic logic [31:0] note_rate(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'd93641024;
            1:       v = 32'd99206586;
            2:       v = 32'd105105008;
            3:       v = 32'd111357765;
            4:       v = 32'd117979172;
            5:       v = 32'd124994286;
            6:       v = 32'd132424579;
            7:       v = 32'd140302265;
            8:       v = 32'd148641660;
            9:       v = 32'd157482134;
            10:      v = 32'd166845163;
            11:      v = 32'd176766537;
            12:      v = 32'd187278471;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Voices past the last note repeat an octave up
    function automatic logic [31:0] voice_rate(input int k);
        int          idx;
        int          dbl;
        logic [63:0] r;
        idx = k;
        dbl = 0;
        while (idx >= NUM_NOTES) begin
            idx = idx - 12;
            dbl = dbl + 1;
        end
        r = 64'(note_rate(idx)) << dbl;
        return r[31:0];
    endfunction

endpackage

[rtl/core/pssm_sine_rom.sv]
// Quarter-wave sine ROM with registered read and sign restore.
module pssm_sine_rom #(
    parameter int ADDR_BITS = pssm_pkg::SINE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic [ADDR_BITS-1:0]                 i_idx,
    output logic signed [pssm_pkg::SAMPLE_W-1:0] o_sine
);
    import pssm_pkg::*;

    localparam int QBITS   = ADDR_BITS - 2;
    localparam int QUARTER = 1 << QBITS;

    logic [MAG_W-1:0]     rom_tab [QUARTER+1];
    logic [ADDR_BITS-2:0] rom_addr;
    logic [1:0]           quad;
    logic [QBITS-1:0]     j;
    logic [MAG_W-1:0]     r_mag;
    logic                 r_neg;

    for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
        localparam logic [MAG_W-1:0] MAG = sine_mag(g, QBITS);
        assign rom_tab[g] = MAG;
    end

    assign quad = i_idx[ADDR_BITS-1 -: 2];
    assign j    = i_idx[QBITS-1:0];
    // odd quadrants run backwards through the quarter
    assign rom_addr = quad[0] ? ((ADDR_BITS-1)'(QUARTER) - {1'b0, j}) : {1'b0, j};

    always_ff @(posedge i_clk) begin
        r_mag <= rom_tab[rom_addr];
        r_neg <= quad[1];
    end

    assign o_sine = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});

endmodule

[rtl/core/pssm_voice_mem.sv]
// Voice state memory: envelope and phase per voice, registered read, valid bits.
module pssm_voice_mem #(
    parameter int VOICES = pssm_pkg::VOICES_DEF,
    parameter int IDX_W  = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clr,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  pssm_pkg::t_voice i_wr_data,
    output pssm_pkg::t_voice o_rd_data
);
    import pssm_pkg::*;

    t_voice            mem [VOICES];
    t_voice            r_rd;
    logic              r_rd_vld;
    logic [VOICES-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= mem[i_rd_addr];
        end
    end

    // unwritten entries read as silent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd : '0;

endmodule

[rtl/core/pssm_mac.sv]
// Two-stage multiply (sine x envelope x amplitude) and voice accumulator.
module pssm_mac #(
    parameter int ACC_W = 50
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_clr,
    input  pssm_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [pssm_pkg::SAMPLE_W-1:0] i_sine,
    input  logic [pssm_pkg::AMP_W-1:0]           i_amp,
    output logic signed [ACC_W-1:0]              o_acc
);
    import pssm_pkg::*;

    t_mac_ctl                r_a;
    logic                    r_b_vld;
    logic signed [P1_W-1:0]  r_b_p1;
    logic                    r_c_vld;
    logic signed [PROD_W-1:0] r_c_p2;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [P1_W:0]    p1;
    logic signed [P1_W+AMP_W:0] p2;

    // sine arrives from the ROM in step with r_a
    assign p1 = i_sine * $signed({1'b0, r_a.vol});
    assign p2 = r_b_p1 * $signed({1'b0, i_amp});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a     <= '0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a     <= i_ctl;
            r_b_vld <= r_a.vld && r_a.snd;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_p1 <= p1[P1_W-1:0];
        r_c_p2 <= p2[PROD_W-1:0];
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_c_vld) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_c_p2[PROD_W-1]}}, r_c_p2};
        end
    end

    assign o_acc = r_acc;

endmodule

[rtl/core/polyphonic_sine_synth_mixer.sv]
// Top level of the polyphonic sine synth mixer: control, voice sequencer, mix and output.
//
// Input channel (i_in_valid / o_in_stall) carries one item per transfer:
//   action = control: with pad valid and synth on, latches keys and steps octave from stick; no result.
//   action = audio:   one stereo frame; returns one frame with the synth sum added.
// Output channel (o_out_valid / i_out_stall) carries the mixed frame.
// Config port (i_cfg_valid / o_cfg_ready) writes registers 0..5; always ready.
// Control items leave the sequencer idle, so the next item can follow right away.
// An audio item walks the voice memory one voice per cycle, then drains the
// 4-stage multiply/accumulate pipe and saturates into the output register.
// No new item is taken until the frame has been loaded into the output
// register: the single memory read port and the shared multiplier serve
// one voice at a time.
// An audio frame while the synth is inactive clears the voices and comes
// back unchanged through the output stage.
// If the receiver stalls, the frame sits in the output register; one more
// item can be taken, and a second finished frame waits with o_in_stall high.
// Reset (synchronous, active low) loads register defaults, octave 0, no
// cooldown, no keys; voice entries are marked invalid so no clearing pass runs.
module polyphonic_sine_synth_mixer #(
    parameter int VOICES               = pssm_pkg::VOICES_DEF,
    parameter int SINE_TABLE_ADDR_BITS = pssm_pkg::SINE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input items
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_action,
    input  logic [pssm_pkg::KEY_W-1:0]           i_key_mask,
    input  logic [pssm_pkg::STICK_W-1:0]         i_stick_x,
    input  logic                                 i_pad_valid,
    input  logic                                 i_synth_active,
    input  logic signed [pssm_pkg::SAMPLE_W-1:0] i_in_left,
    input  logic signed [pssm_pkg::SAMPLE_W-1:0] i_in_right,
    // results
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [pssm_pkg::SAMPLE_W-1:0] o_out_left,
    output logic signed [pssm_pkg::SAMPLE_W-1:0] o_out_right,
    // configuration
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pssm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pssm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import pssm_pkg::*;

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ACC_W  = PROD_W + $clog2(VOICES + 1);
    localparam int MIX_W  = ACC_W - MIX_SHIFT;

    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'((64'd1 << MIX_SHIFT) - 64'd1);
    localparam logic signed [MIX_W:0] SAT_HI = (MIX_W+1)'(32767);
    localparam logic signed [MIX_W:0] SAT_LO = (MIX_W+1)'(-32768);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_PUSH  = 4'b1000
    } t_state;

    t_state r_state;
    logic [VIDX_W-1:0] r_cnt;
    logic [1:0]        r_drn;
    logic              r_e_vld;
    logic [VIDX_W-1:0] r_e_idx;

    // key / octave state
    logic [KEY_W-1:0]   r_held;
    logic [2:0]         r_oct;
    logic [STICK_W-1:0] r_cool;

    // registers
    logic [15:0]        r_attack;
    logic [15:0]        r_release;
    logic [AMP_W-1:0]   r_amp;
    logic [STICK_W-1:0] r_stk_lo;
    logic [STICK_W-1:0] r_stk_hi;
    logic [STICK_W-1:0] r_cdn;

    logic signed [SAMPLE_W-1:0] r_left;
    logic signed [SAMPLE_W-1:0] r_right;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_l;
    logic signed [SAMPLE_W-1:0] r_out_r;

    logic in_xfer;
    logic out_xfer;
    logic push_load;
    logic clr_voices;
    logic acc_clr;

    logic [VOICES-1:0] held_vec;
    logic [31:0]       base_tab [VOICES];

    // voice update stage
    t_voice      cur;
    t_voice      upd;
    logic        held;
    logic        dead;
    logic        snd;
    logic [16:0] att_sum;
    logic [VOL_W-1:0] n_vol;
    logic [2:0]  oct_sh;
    logic [39:0] step_sh;
    logic [31:0] step;
    t_mac_ctl    mac_ctl;
    logic signed [SAMPLE_W-1:0] sine;
    logic signed [ACC_W-1:0]    acc;

    // mix
    logic [ACC_W-1:0]        acc_rnd;
    logic signed [MIX_W-1:0] mix;
    logic signed [MIX_W:0]   sum_l;
    logic signed [MIX_W:0]   sum_r;

    // keys beyond the last note are never held
    for (genvar g = 0; g < VOICES; g++) begin : g_voice
        localparam logic [31:0] RATE = voice_rate(g);
        assign base_tab[g] = RATE;
        if (g < NUM_NOTES) begin : g_key
            assign held_vec[g] = r_held[g];
        end else begin : g_nokey
            assign held_vec[g] = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_out_valid && !i_out_stall;
    assign push_load   = (r_state == ST_PUSH) && (!r_out_valid || !i_out_stall);
    assign clr_voices  = in_xfer && !i_synth_active;
    assign acc_clr     = in_xfer && (i_action == ACT_AUDIO);

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= 16'd164;
            r_release <= 16'd66;
            r_amp     <= 15'd4000;
            r_stk_lo  <= 8'd50;
            r_stk_hi  <= 8'd200;
            r_cdn     <= 8'd40;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ATTACK:  r_attack  <= i_cfg_data;
                CFG_RELEASE: r_release <= i_cfg_data;
                CFG_AMP:     r_amp     <= i_cfg_data[AMP_W-1:0];
                CFG_STK_LO:  r_stk_lo  <= i_cfg_data[STICK_W-1:0];
                CFG_STK_HI:  r_stk_hi  <= i_cfg_data[STICK_W-1:0];
                CFG_COOL:    r_cdn     <= i_cfg_data[STICK_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Keys and octave. Down step wins if both thresholds trip.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_oct  <= '0;
            r_cool <= '0;
        end else if (clr_voices) begin
            r_held <= '0;
        end else if (in_xfer && (i_action == ACT_CTRL) && i_pad_valid) begin
            r_held <= i_key_mask;
            if (r_cool != '0) begin
                r_cool <= r_cool - 8'd1;
            end else if ((i_stick_x < r_stk_lo) && (r_oct != OCT_MIN)) begin
                r_oct  <= r_oct - 3'd1;
                r_cool <= r_cdn;
            end else if ((i_stick_x > r_stk_hi) && (r_oct != OCT_MAX)) begin
                r_oct  <= r_oct + 3'd1;
                r_cool <= r_cdn;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: one voice read per cycle, then drain the MAC pipe
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_drn   <= '0;
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= (r_state == ST_RUN);
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer && (i_action == ACT_AUDIO)) begin
                        r_cnt   <= '0;
                        // inactive frame: acc stays zero, input passes through
                        r_state <= i_synth_active ? ST_RUN : ST_PUSH;
                    end
                end
                ST_RUN: begin
                    r_cnt <= r_cnt + VIDX_W'(1);
                    if (r_cnt == VIDX_W'(VOICES - 1)) begin
                        r_drn   <= 2'd3;
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_drn <= r_drn - 2'd1;
                    if (r_drn == 2'd0) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (push_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_idx <= r_cnt;
        if (acc_clr) begin
            r_left  <= i_in_left;
            r_right <= i_in_right;
        end
    end

    // ---------------------------------------------------------------
    // Voice state memory; read in RUN, written back in the next cycle.
    // Each entry is touched once per frame, so no forwarding is needed.
    // ---------------------------------------------------------------
    pssm_voice_mem #(
        .VOICES (VOICES),
        .IDX_W  (VIDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (clr_voices),
        .i_rd_en   (r_state == ST_RUN),
        .i_rd_addr (r_cnt),
        .i_wr_en   (r_e_vld),
        .i_wr_addr (r_e_idx),
        .i_wr_data (upd),
        .o_rd_data (cur)
    );

    // Envelope: attack clamps at full scale; release past zero kills the
    // voice and resets its phase. Only a voice still sounding advances.
    always_comb begin
        held    = held_vec[r_e_idx];
        att_sum = {1'b0, cur.vol} + {1'b0, r_attack};
        dead    = 1'b0;
        if (held) begin
            n_vol = (att_sum > {1'b0, VOL_MAX}) ? VOL_MAX : att_sum[VOL_W-1:0];
        end else if (r_release > cur.vol) begin
            n_vol = '0;
            dead  = 1'b1;
        end else begin
            n_vol = cur.vol - r_release;
        end
        snd = (n_vol != '0);

        // increment = (rate << (octave + 2)) >> 4
        oct_sh  = r_oct + OCT_BIAS;
        step_sh = {8'd0, base_tab[r_e_idx]} << oct_sh;
        step    = step_sh[35:4];

        upd.vol = n_vol;
        if (snd) begin
            upd.phase = cur.phase + step;
        end else if (dead) begin
            upd.phase = '0;
        end else begin
            upd.phase = cur.phase;
        end

        mac_ctl.vld = r_e_vld;
        mac_ctl.snd = snd;
        mac_ctl.vol = n_vol;
    end

    // sine of the phase before this frame's advance
    pssm_sine_rom #(
        .ADDR_BITS (SINE_TABLE_ADDR_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_idx  (cur.phase[PHASE_W-1 -: SINE_TABLE_ADDR_BITS]),
        .o_sine (sine)
    );

    pssm_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (acc_clr),
        .i_ctl   (mac_ctl),
        .i_sine  (sine),
        .i_amp   (r_amp),
        .o_acc   (acc)
    );

    // ---------------------------------------------------------------
    // Mix: acc / 2^30 truncated toward zero, added to both channels
    // ---------------------------------------------------------------
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [MIX_W:0] v);
        logic signed [SAMPLE_W-1:0] s;
        if (v > SAT_HI) begin
            s = 16'sh7FFF;
        end else if (v < SAT_LO) begin
            s = -16'sh8000;
        end else begin
            s = v[SAMPLE_W-1:0];
        end
        return s;
    endfunction

    assign acc_rnd = acc + (acc[ACC_W-1] ? ROUND_BIAS : '0);
    assign mix     = acc_rnd[ACC_W-1:MIX_SHIFT];
    assign sum_l   = $signed({{(MIX_W-15){r_left[SAMPLE_W-1]}}, r_left})
                   + $signed({mix[MIX_W-1], mix});
    assign sum_r   = $signed({{(MIX_W-15){r_right[SAMPLE_W-1]}}, r_right})
                   + $signed({mix[MIX_W-1], mix});

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            if (push_load) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_load) begin
            r_out_l <= sat16(sum_l);
            r_out_r <= sat16(sum_r);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;

endmodule
